/* hw/rtl/sync_header_checksum_deframer_macros.svh */
// Assertion macros for the header-sync checksum deframer checker.
`ifndef SYNC_HEADER_CHECKSUM_DEFRAMER_MACROS_SVH
`define SYNC_HEADER_CHECKSUM_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define SHCD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must never hold.
`define SHCD_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

/* hw/rtl/shcd_pkg.sv */
// Shared constants and control structs for the header-sync checksum deframer.
`default_nettype none
package shcd_pkg;

  localparam int PACKET_BYTES = 12;
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;

  localparam int BYTE_W      = 8;
  localparam int IDX_W       = 6;
  localparam int SUM_W       = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // Window memory control
  typedef struct packed {
    logic wr_en;
    logic head_adv;
    logic head_clr;
  } shcd_win_ctl_t;

  // Checker unit control
  typedef struct packed {
    logic start;
    logic en;
  } shcd_chk_ctl_t;

endpackage
`default_nettype wire

/* hw/rtl/shcd_window.sv */
// Circular byte window: one write port, one registered read port, head-relative offsets.
`default_nettype none
module shcd_window #(
  parameter int PACKET_BYTES = shcd_pkg::PACKET_BYTES
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire shcd_pkg::shcd_win_ctl_t       ctl,
  input  wire logic [$clog2(PACKET_BYTES)-1:0] wr_off,
  input  wire logic [shcd_pkg::BYTE_W-1:0]   wr_data,
  input  wire logic [$clog2(PACKET_BYTES)-1:0] rd_off,
  output logic      [shcd_pkg::BYTE_W-1:0]   rd_data
);

  localparam int AW = $clog2(PACKET_BYTES);
  localparam logic [AW:0] DEPTH = (AW+1)'(PACKET_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PACKET_BYTES - 1);

  logic [shcd_pkg::BYTE_W-1:0] mem_r [PACKET_BYTES];
  logic [shcd_pkg::BYTE_W-1:0] rd_data_r;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW:0]   wr_sum, rd_sum;
  logic [AW-1:0] wr_addr, rd_addr;

  // head + offset, wrapped once (both below depth)
  always_comb begin
    wr_sum  = {1'b0, head_r} + {1'b0, wr_off};
    rd_sum  = {1'b0, head_r} + {1'b0, rd_off};
    wr_addr = (wr_sum >= DEPTH) ? AW'(wr_sum - DEPTH) : wr_sum[AW-1:0];
    rd_addr = (rd_sum >= DEPTH) ? AW'(rd_sum - DEPTH) : rd_sum[AW-1:0];
  end

  always_comb begin
    head_nxt = head_r;
    if (ctl.head_clr) begin
      head_nxt = '0;
    end else if (ctl.head_adv) begin
      head_nxt = (head_r == LAST_ADDR) ? '0 : head_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
    end else begin
      head_r <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

/* hw/rtl/shcd_checker.sv */
// Shared accumulate/compare unit: sums the window bytes ahead of the checksum one by one and checks sync and checksum.
`default_nettype none
module shcd_checker #(
  parameter int PACKET_BYTES = shcd_pkg::PACKET_BYTES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire shcd_pkg::shcd_chk_ctl_t         ctl,
  input  wire logic [$clog2(PACKET_BYTES)-1:0] idx,
  input  wire logic [shcd_pkg::BYTE_W-1:0]     data,
  output logic                                 frame_ok
);

  localparam int AW = $clog2(PACKET_BYTES);
  localparam logic [AW-1:0] CKS_LO_IDX = AW'(PACKET_BYTES - 2);
  localparam logic [AW-1:0] FIRST_IDX  = AW'(0);
  localparam logic [AW-1:0] SECOND_IDX = AW'(1);

  logic [shcd_pkg::SUM_W-1:0]  sum_r;
  logic [shcd_pkg::BYTE_W-1:0] cks_lo_r;
  logic                        hdr_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r    <= '0;
      hdr_ok_r <= 1'b0;
    end else if (ctl.start) begin
      sum_r    <= '0;
      hdr_ok_r <= 1'b1;
    end else if (ctl.en) begin
      if (idx < CKS_LO_IDX) begin
        sum_r <= sum_r + shcd_pkg::SUM_W'(data);
      end
      if (idx == FIRST_IDX && data != shcd_pkg::SYNC_FIRST) begin
        hdr_ok_r <= 1'b0;
      end
      if (idx == SECOND_IDX && data != shcd_pkg::SYNC_SECOND) begin
        hdr_ok_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en && idx == CKS_LO_IDX) begin
      cks_lo_r <= data;
    end
  end

  // Valid only while the last window byte (checksum high) is on data
  assign frame_ok = hdr_ok_r && (sum_r == {data, cks_lo_r});

endmodule
`default_nettype wire

/* hw/rtl/sync_header_checksum_deframer.sv */
// A byte that does not fill the window is written and taken without leaving idle.
// A byte that fills the window starts a check sweep: one window read
// per cycle through the single memory read port into the shared sum/compare unit.
// A valid frame then emits PACKET_BYTES-4 payload transfers, each through the read, load and wait states.
// in_tready is low throughout check and emission. Reset (rst_n low, synchronous) empties the
// window and idles the sequencer; window contents are left as they are.
`default_nettype none
module sync_header_checksum_deframer #(
  parameter int PACKET_BYTES = shcd_pkg::PACKET_BYTES
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [shcd_pkg::IN_TDATA_W-1:0]     in_tdata,   // [7:0] rx_byte
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic      [shcd_pkg::OUT_TDATA_W-1:0]    out_tdata,  // [7:0] payload_byte,
                                                               // [13:8] payload_index, [15:14] 0
  output logic                                     out_tlast   // last_of_packet
);

  localparam int AW = $clog2(PACKET_BYTES);
  localparam int CW = $clog2(PACKET_BYTES + 1);
  localparam int IW = shcd_pkg::IDX_W;

  localparam logic [AW-1:0] LAST_OFF    = AW'(PACKET_BYTES - 1);
  localparam logic [CW-1:0] RD_END      = CW'(PACKET_BYTES);
  localparam logic [IW-1:0] LAST_PIDX   = IW'(PACKET_BYTES - 5);

  // sequencer states
  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_CHECK     = 3'd1;
  localparam logic [2:0] S_EMIT_RD   = 3'd2;
  localparam logic [2:0] S_EMIT_LD   = 3'd3;
  localparam logic [2:0] S_EMIT_WAIT = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] fill_r, fill_nxt;        // bytes held, 0..PACKET_BYTES-1 between items
  logic [CW-1:0] rd_cnt_r, rd_cnt_nxt;    // next window offset to read during check
  logic          dv_r, dv_nxt;            // read data valid for the checker
  logic [AW-1:0] didx_r, didx_nxt;        // window offset of that read data
  logic [IW-1:0] pidx_r, pidx_nxt;        // payload byte being emitted

  logic                         out_valid_r, out_valid_nxt;
  logic [shcd_pkg::BYTE_W-1:0]  out_byte_r;
  logic [IW-1:0]                out_idx_r;
  logic                         out_last_r;
  logic                         out_load;

  shcd_pkg::shcd_win_ctl_t win_ctl;
  shcd_pkg::shcd_chk_ctl_t chk_ctl;
  logic [AW-1:0]               rd_off;
  logic [shcd_pkg::BYTE_W-1:0] rd_data;
  logic                        frame_ok;
  logic                        in_xfer, out_xfer;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_xfer  = out_valid_r && out_tready;

  // Read port: check sweep walks the window, emission reads header-relative payload
  always_comb begin
    if (state_r == S_CHECK) begin
      rd_off = rd_cnt_r[AW-1:0];
    end else begin
      rd_off = AW'({1'b0, pidx_r} + (IW+1)'(2));
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    rd_cnt_nxt    = rd_cnt_r;
    dv_nxt        = 1'b0;
    didx_nxt      = didx_r;
    pidx_nxt      = pidx_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    win_ctl       = '0;
    chk_ctl       = '0;
    chk_ctl.en    = dv_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          win_ctl.wr_en = 1'b1;
          if (fill_r == LAST_OFF) begin
            // window full: start the check sweep
            chk_ctl.start = 1'b1;
            rd_cnt_nxt    = '0;
            state_nxt     = S_CHECK;
          end else begin
            fill_nxt = fill_r + AW'(1);
          end
        end
      end
      S_CHECK: begin
        if (rd_cnt_r != RD_END) begin
          dv_nxt     = 1'b1;
          didx_nxt   = rd_cnt_r[AW-1:0];
          rd_cnt_nxt = rd_cnt_r + CW'(1);
        end
        if (dv_r && didx_r == LAST_OFF) begin
          if (frame_ok) begin
            pidx_nxt  = '0;
            state_nxt = S_EMIT_RD;
          end else begin
            // slide by one: drop the oldest byte
            win_ctl.head_adv = 1'b1;
            fill_nxt         = LAST_OFF;
            state_nxt        = S_IDLE;
          end
        end
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_xfer) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // frame consumed: window empty
            win_ctl.head_clr = 1'b1;
            fill_nxt         = '0;
            state_nxt        = S_IDLE;
          end else begin
            pidx_nxt  = pidx_r + IW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      rd_cnt_r    <= '0;
      dv_r        <= 1'b0;
      didx_r      <= '0;
      pidx_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      dv_r        <= dv_nxt;
      didx_r      <= didx_nxt;
      pidx_r      <= pidx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte_r <= rd_data;
      out_idx_r  <= pidx_r;
      out_last_r <= (pidx_r == LAST_PIDX);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(shcd_pkg::OUT_TDATA_W - shcd_pkg::BYTE_W - IW)'(0), out_idx_r, out_byte_r};
  assign out_tlast  = out_last_r;

  shcd_window #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .wr_off  (fill_r),
    .wr_data (in_tdata[shcd_pkg::BYTE_W-1:0]),
    .rd_off  (rd_off),
    .rd_data (rd_data)
  );

  shcd_checker #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (chk_ctl),
    .idx      (didx_r),
    .data     (rd_data),
    .frame_ok (frame_ok)
  );

endmodule
`default_nettype wire

/* hw/rtl/shcd_sva.sv */
// Port-level checker for the deframer and its bind.
`default_nettype none
`include "sync_header_checksum_deframer_macros.svh"
module shcd_sva (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             in_tready,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [shcd_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                             out_tlast
);

  logic out_xfer;
  assign out_xfer = out_tvalid && out_tready;

  `SHCD_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled result changed")
  `SHCD_ASSERT_NEVER(a_no_overlap, in_tready && out_tvalid, "input taken while a result is pending")
  `SHCD_ASSERT_NEXT(a_run_continues, out_xfer && !out_tlast, !in_tready, "input reopened inside a payload run")
  `SHCD_ASSERT_NEXT(a_run_ends, out_xfer && out_tlast, in_tready && !out_tvalid, "no return to idle after last payload byte")
  `SHCD_ASSERT_IMPL(a_pad_zero, out_tvalid, out_tdata[15:14] == 2'b00, "tdata padding not zero")

endmodule

bind sync_header_checksum_deframer shcd_sva u_shcd_sva (.*);
`default_nettype wire
